>>> rtl/rcm_pkg.sv
`default_nettype none
package rcm_pkg;
    localparam int REG_W = 16;
    localparam int DATA_W = 32;

    typedef enum logic [2:0]
    {
        CFG_PRIME_P    = 3'd0,
        CFG_PRIME_Q    = 3'd1,
        CFG_EXPONENT_P = 3'd2,
        CFG_EXPONENT_Q = 3'd3,
        CFG_Q_INVERSE  = 3'd4
    } cfg_index_t;

    // Datapath operation codes issued by the controller
    typedef enum logic [3:0]
    {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,  // latch ciphertext, set up exponentiation mod p
        OP_RED     = 4'd2,  // reduce x mod m (x = base, one, m2, qi or diff)
        OP_MUL     = 4'd3,  // x = a * b, then reduce
        OP_SHIFT   = 4'd4,  // exponent >>= 1
        OP_SETUP_Q = 4'd5,  // store m1, set up exponentiation mod q
        OP_DIFF    = 4'd6,  // store m2 ahead of the diff steps, x = m1 + p - (m2 mod p)
        OP_FINAL   = 4'd7   // result = m2 + h * q
    } op_t;

    // Multiply / reduce operand selection
    typedef enum logic [2:0]
    {
        SEL_ACC_SQ  = 3'd0,
        SEL_SQ_SQ   = 3'd1,
        SEL_BASE    = 3'd2,
        SEL_ONE     = 3'd3,
        SEL_QI_DIFF = 3'd4,
        SEL_M2      = 3'd5,
        SEL_QI      = 3'd6,
        SEL_DIFF    = 3'd7
    } sel_t;

    typedef enum logic [1:0]
    {
        DST_ACC  = 2'd0,
        DST_SQ   = 2'd1,
        DST_TMP  = 2'd2,
        DST_DIFF = 2'd3
    } dst_t;

    typedef struct packed
    {
        op_t  op;
        sel_t sel;
        dst_t dst;
        logic mod_p;    // reduce by p rather than the active modulus
        logic red_go;   // start the serial reducer
    } cmd_t;

    typedef struct packed
    {
        logic red_done;
        logic exp_zero;
        logic exp_bit;
        logic p_zero;
    } sts_t;
endpackage
`default_nettype wire

>>> rtl/rcm_ctrl.sv
`default_nettype none
module rcm_ctrl
    import rcm_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  start,
    output logic busy,
    output logic done,
    output cmd_t cmd,
    input  sts_t sts
);
    typedef enum logic [12:0]
    {
        S_IDLE   = 13'b0000000000001,
        S_RBASE  = 13'b0000000000010,
        S_RONE   = 13'b0000000000100,
        S_TEST   = 13'b0000000001000,
        S_MULA   = 13'b0000000010000,
        S_MULS   = 13'b0000000100000,
        S_RED    = 13'b0000001000000,
        S_SHIFT  = 13'b0000010000000,
        S_NEXT   = 13'b0000100000000,
        S_DIFF   = 13'b0001000000000,
        S_H      = 13'b0010000000000,
        S_FINAL  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   phase_q_reg, phase_q_next;
    logic   [1:0] dstep_reg, dstep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            phase_q_reg <= 1'b0;
            dstep_reg   <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            phase_q_reg <= phase_q_next;
            dstep_reg   <= dstep_next;
        end
    end

    // Sequence the two exponentiations and the recombination
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        phase_q_next = phase_q_reg;
        dstep_next   = dstep_reg;
        cmd          = '{op: OP_NONE, sel: SEL_BASE, dst: DST_ACC, mod_p: 1'b0,
                         red_go: 1'b0};
        done         = 1'b0;
        busy         = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op       = OP_LOAD;
                    phase_q_next = 1'b0;
                    state_next   = S_RBASE;
                end
            end
            S_RBASE:
            begin
                cmd.op = OP_RED; cmd.sel = SEL_BASE; cmd.dst = DST_SQ; cmd.red_go = 1'b1;
                ret_next   = S_RONE;
                state_next = S_RED;
            end
            S_RONE:
            begin
                cmd.op = OP_RED; cmd.sel = SEL_ONE; cmd.dst = DST_ACC; cmd.red_go = 1'b1;
                ret_next   = S_TEST;
                state_next = S_RED;
            end
            S_TEST:
            begin
                if (sts.exp_zero)
                    state_next = S_NEXT;
                else if (sts.exp_bit)
                    state_next = S_MULA;
                else
                    state_next = S_MULS;
            end
            S_MULA:
            begin
                cmd.op = OP_MUL; cmd.sel = SEL_ACC_SQ; cmd.dst = DST_ACC; cmd.red_go = 1'b1;
                ret_next   = S_MULS;
                state_next = S_RED;
            end
            S_MULS:
            begin
                cmd.op = OP_MUL; cmd.sel = SEL_SQ_SQ; cmd.dst = DST_SQ; cmd.red_go = 1'b1;
                ret_next   = S_SHIFT;
                state_next = S_RED;
            end
            S_RED:
            begin
                if (sts.red_done)
                    state_next = ret_reg;
            end
            S_SHIFT:
            begin
                cmd.op     = OP_SHIFT;
                state_next = S_TEST;
            end
            S_NEXT:
            begin
                if (!phase_q_reg)
                begin
                    cmd.op       = OP_SETUP_Q;
                    phase_q_next = 1'b1;
                    state_next   = S_RBASE;
                end
                else if (sts.p_zero)
                begin
                    cmd.op = OP_DIFF;
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.op     = OP_DIFF;
                    dstep_next = 2'd0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // diff = (m1 + p - m2 mod p) mod p, then qi mod p
                cmd.mod_p  = 1'b1;
                cmd.red_go = 1'b1;
                cmd.op     = OP_RED;
                case (dstep_reg)
                    2'd0:
                    begin
                        cmd.sel = SEL_M2; cmd.dst = DST_TMP;
                    end
                    2'd1:
                    begin
                        cmd.sel = SEL_DIFF; cmd.dst = DST_DIFF;
                    end
                    default:
                    begin
                        cmd.sel = SEL_QI; cmd.dst = DST_ACC;
                    end
                endcase
                dstep_next = dstep_reg + 2'd1;
                ret_next   = (dstep_reg == 2'd2) ? S_H : S_DIFF;
                state_next = S_RED;
            end
            S_H:
            begin
                cmd.op = OP_MUL; cmd.sel = SEL_QI_DIFF; cmd.dst = DST_ACC;
                cmd.mod_p = 1'b1; cmd.red_go = 1'b1;
                ret_next   = S_FINAL;
                state_next = S_RED;
            end
            S_FINAL:
            begin
                cmd.op     = OP_FINAL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/rcm_datapath.sv
`default_nettype none
module rcm_datapath
    import rcm_pkg::*;
#(
    parameter int PRIME_BITS = 16
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire  [DATA_W-1:0]  ciphertext,
    input  wire  [REG_W-1:0]   prime_p,
    input  wire  [REG_W-1:0]   prime_q,
    input  wire  [REG_W-1:0]   exponent_p,
    input  wire  [REG_W-1:0]   exponent_q,
    input  wire  [REG_W-1:0]   q_inverse,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic [DATA_W-1:0]  plaintext
);
    localparam int MB = PRIME_BITS;
    localparam int XW = (2 * MB > DATA_W) ? 2 * MB : DATA_W;  // dividend width
    localparam int CW = $clog2(XW + 1);

    logic [DATA_W-1:0] c_reg;
    logic [MB-1:0]     mod_reg, acc_reg, sq_reg, m1_reg, m2_reg, tmp_reg, diff_reg;
    logic [REG_W-1:0]  exp_reg;
    logic [MB-1:0]     pm, qm;

    // Serial restoring reducer: one dividend bit per cycle
    logic [XW-1:0]     rx_reg;
    logic [MB:0]       rr_reg;
    logic [MB-1:0]     rm_reg;
    logic [CW-1:0]     rcnt_reg;
    logic              rbusy_reg;
    dst_t              rdst_reg;
    logic [XW-1:0]     rx_in;
    logic [MB:0]       rr_sh;
    logic [MB-1:0]     rres;
    logic [MB-1:0]     op_a, op_b;
    logic [2*MB-1:0]   prod;
    logic [MB:0]       dsum;

    assign pm = MB'(prime_p);
    assign qm = MB'(prime_q);

    // Operand selection for multiply / reduce
    always_comb
    begin
        op_a = acc_reg;
        op_b = sq_reg;
        case (cmd.sel)
            SEL_ACC_SQ:  begin op_a = acc_reg; op_b = sq_reg;  end
            SEL_SQ_SQ:   begin op_a = sq_reg;  op_b = sq_reg;  end
            SEL_QI_DIFF: begin op_a = acc_reg; op_b = diff_reg; end
            default:     begin op_a = acc_reg; op_b = sq_reg;  end
        endcase
        prod = op_a * op_b;
        dsum = {1'b0, m1_reg} + {1'b0, pm} - {1'b0, tmp_reg};
        case (cmd.sel)
            SEL_BASE: rx_in = XW'(c_reg);
            SEL_ONE:  rx_in = XW'(1);
            SEL_M2:   rx_in = XW'(m2_reg);
            SEL_QI:   rx_in = XW'(q_inverse);
            SEL_DIFF: rx_in = XW'(dsum);
            default:  rx_in = XW'(prod);
        endcase
    end

    assign rr_sh = {rr_reg[MB-1:0], rx_reg[XW-1]};
    assign rres  = (rr_sh >= {1'b0, rm_reg}) ? MB'(rr_sh - {1'b0, rm_reg}) : rr_sh[MB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbusy_reg <= 1'b0;
            rcnt_reg  <= '0;
        end
        else if (cmd.red_go)
        begin
            rbusy_reg <= 1'b1;
            rcnt_reg  <= CW'(XW);
        end
        else if (rbusy_reg)
        begin
            rcnt_reg <= rcnt_reg - CW'(1);
            if (rcnt_reg == CW'(1))
                rbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.red_go)
        begin
            rx_reg   <= rx_in;
            rr_reg   <= '0;
            rm_reg   <= cmd.mod_p ? pm : mod_reg;
            rdst_reg <= cmd.dst;
        end
        else if (rbusy_reg)
        begin
            rx_reg <= {rx_reg[XW-2:0], 1'b0};
            rr_reg <= {1'b0, rres};
            if (rcnt_reg == CW'(1))
            begin
                case (rdst_reg)
                    DST_ACC:  acc_reg  <= rres;
                    DST_SQ:   sq_reg   <= rres;
                    DST_TMP:  tmp_reg  <= rres;
                    default:  diff_reg <= rres;
                endcase
            end
        end

        case (cmd.op)
            OP_LOAD:
            begin
                c_reg   <= ciphertext;
                mod_reg <= pm;
                exp_reg <= exponent_p;
            end
            OP_SHIFT:   exp_reg <= exp_reg >> 1;
            OP_SETUP_Q:
            begin
                m1_reg  <= (mod_reg == '0) ? '0 : acc_reg;
                mod_reg <= qm;
                exp_reg <= exponent_q;
            end
            OP_DIFF:    m2_reg <= (mod_reg == '0) ? '0 : acc_reg;
            OP_FINAL:
            begin
                if (pm == '0)
                    plaintext <= DATA_W'(m2_reg);
                else
                    plaintext <= DATA_W'({{MB{1'b0}}, m2_reg} + acc_reg * qm);
            end
            default:    ;
        endcase
    end

    // Modulo zero: the serial divider leaves the dividend, force zero later
    assign sts.red_done = rbusy_reg && (rcnt_reg == CW'(1));
    assign sts.exp_zero = (exp_reg == '0) || (mod_reg == '0);
    assign sts.exp_bit  = exp_reg[0];
    assign sts.p_zero   = (pm == '0);
endmodule
`default_nettype wire

>>> rtl/rsa_crt_modexp.sv
// rsa_crt_modexp: RSA private-key step by the Chinese remainder method.
// Input stream s_axis_*: tdata[31:0] = ciphertext. Output stream m_axis_*:
// tdata[31:0] = plaintext. Configuration channel cfg_*: cfg_index selects
// 0 prime_p, 1 prime_q, 2 exponent_p, 3 exponent_q, 4 q_inverse; other
// indexes are ignored. Write only while idle.
// One item at a time: s_axis_tready is high when no item is in work and the
// output register is free. Each modular multiplication is reduced by a
// serial restoring divider over max(2*PRIME_BITS,32) dividend bits, one
// dividend bit a cycle. Reset restores the register defaults (61, 53, 53,
// 49, 38) and empties the output. A stalled receiver holds the result in
// m_axis_tdata; the next item is taken once it has been delivered.
`default_nettype none
module rsa_crt_modexp
    import rcm_pkg::*;
#(
    parameter int PRIME_BITS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] ciphertext
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] plaintext
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    logic [REG_W-1:0] prime_p_reg, prime_q_reg, exp_p_reg, exp_q_reg, qinv_reg;
    logic busy, done, start, ovalid_reg;
    cmd_t cmd;
    sts_t sts;
    logic [DATA_W-1:0] result;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy && !ovalid_reg;
    assign start         = s_axis_tvalid && s_axis_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg <= 16'd61;
            prime_q_reg <= 16'd53;
            exp_p_reg   <= 16'd53;
            exp_q_reg   <= 16'd49;
            qinv_reg    <= 16'd38;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRIME_P:    prime_p_reg <= cfg_data;
                CFG_PRIME_Q:    prime_q_reg <= cfg_data;
                CFG_EXPONENT_P: exp_p_reg   <= cfg_data;
                CFG_EXPONENT_Q: exp_q_reg   <= cfg_data;
                CFG_Q_INVERSE:  qinv_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = result;

    rcm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    rcm_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ciphertext (s_axis_tdata),
        .prime_p    (prime_p_reg),
        .prime_q    (prime_q_reg),
        .exponent_p (exp_p_reg),
        .exponent_q (exp_q_reg),
        .q_inverse  (qinv_reg),
        .cmd        (cmd),
        .sts        (sts),
        .plaintext  (result)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("input accepted while busy");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !ovalid_reg) else $error("result overwritten");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule
`default_nettype wire
